// File: rtl/ffdl_pkg.sv
// Shared definitions for the fractional feedback delay line: sizes, arithmetic helpers,
// the microcode control word and the microprogram itself.
// Depends on nothing; used by ffdl_seq and fractional_feedback_delay_line.
package ffdl_pkg;

   // Store geometry and fixed-point format.
   localparam int MAX_FRAMES   = 4096;
   localparam int MAX_CHANNELS = 8;
   localparam int FRAC_BITS    = 8;
   localparam int STORE_DEPTH  = MAX_FRAMES * MAX_CHANNELS;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int LEN_W  = ADDR_W + 1;
   localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
   localparam int POS_W  = ADDR_W + FRAC_BITS;
   localparam int SPAN_W = LEN_W + FRAC_BITS;
   localparam int DLY_W  = $clog2(MAX_FRAMES) + FRAC_BITS + 1;
   localparam int SCALE  = 2 ** FRAC_BITS;

   // Field and register widths.
   localparam int SMP_W   = 16;
   localparam int DELAY_W = 20;
   localparam int CHREG_W = 4;
   localparam int FB_W    = 15;
   localparam int GAIN_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   // Datapath widths: interpolated value, multiplier operands and products.
   localparam int WET_W  = SMP_W + FRAC_BITS + 1;
   localparam int MULB_W = GAIN_W + 1;
   localparam int MUL_W  = WET_W + MULB_W;
   localparam int SUM_W  = MUL_W + 1;
   localparam int SHIFT  = FRAC_BITS + 15;
   localparam int RND_W  = SUM_W - SHIFT;
   localparam int SAT_W  = RND_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WET      = 3'd4;

   // Microprogram step addresses.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_CLR   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RDP   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RDN   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MNEXT = 4'd4;
   localparam logic [STEP_W-1:0] STEP_WET   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FB    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_STORE = 4'd7;
   localparam logic [STEP_W-1:0] STEP_OUT   = 4'd8;

   // Jump conditions: the step moves to its target when the condition holds.
   typedef enum logic [1:0] {
      C_ALWAYS,
      C_CLR_DONE,
      C_REQ,
      C_OUT_FREE
   } cond_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_PREV,
      RD_NEXT
   } rd_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_PREV,
      MUL_NEXT,
      MUL_DRY,
      MUL_FB,
      MUL_WG
   } mul_type;

   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              req_rdy;
      logic              clr_wr;
      rd_type            rd_sel;
      mul_type           mul_sel;
      logic              nidx_ld;
      logic              acc_ld;
      logic              wet_ld;
      logic              st_wr;
      logic              out_ld;
   } ctrl_word_type;

   // Sequencer output: the current control word and whether the step completes.
   typedef struct packed {
      ctrl_word_type word;
      logic          go;
   } seq_ctrl_type;

   // Status fed back to the sequencer for its conditional jumps.
   typedef struct packed {
      logic req_valid;
      logic clr_done;
      logic out_free;
   } seq_status_type;

   localparam ctrl_word_type CTRL_NOP = '{
      cond: C_ALWAYS, target: STEP_IDLE, req_rdy: 1'b0, clr_wr: 1'b0,
      rd_sel: RD_NONE, mul_sel: MUL_HOLD, nidx_ld: 1'b0, acc_ld: 1'b0,
      wet_ld: 1'b0, st_wr: 1'b0, out_ld: 1'b0};

   // The microprogram. One control word per step.
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = CTRL_NOP;
      unique case (step)
         STEP_CLR: begin
            w.cond   = C_CLR_DONE;
            w.target = STEP_IDLE;
            w.clr_wr = 1'b1;
         end
         STEP_IDLE: begin
            w.cond    = C_REQ;
            w.target  = STEP_RDP;
            w.req_rdy = 1'b1;
         end
         STEP_RDP: begin
            w.target  = STEP_RDN;
            w.rd_sel  = RD_PREV;
            w.nidx_ld = 1'b1;
         end
         STEP_RDN: begin
            w.target  = STEP_MNEXT;
            w.rd_sel  = RD_NEXT;
            w.mul_sel = MUL_PREV;
         end
         STEP_MNEXT: begin
            w.target  = STEP_WET;
            w.mul_sel = MUL_NEXT;
            w.acc_ld  = 1'b1;
         end
         STEP_WET: begin
            w.target  = STEP_FB;
            w.mul_sel = MUL_DRY;
            w.wet_ld  = 1'b1;
         end
         STEP_FB: begin
            w.target  = STEP_STORE;
            w.mul_sel = MUL_FB;
            w.acc_ld  = 1'b1;
         end
         STEP_STORE: begin
            w.target  = STEP_OUT;
            w.mul_sel = MUL_WG;
            w.st_wr   = 1'b1;
         end
         STEP_OUT: begin
            w.cond   = C_OUT_FREE;
            w.target = STEP_IDLE;
            w.out_ld = 1'b1;
         end
         default: begin
            w = CTRL_NOP;
         end
      endcase
      return w;
   endfunction

   localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (SHIFT - 1);
   localparam logic signed [SAT_W-1:0] SMP_MAX  = SAT_W'(32767);
   localparam logic signed [SAT_W-1:0] SMP_MIN  = -SAT_W'(32768);

   // Round half up, then floor by 2^SHIFT.
   function automatic logic signed [RND_W-1:0] round_shift(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v + RND_HALF) >>> SHIFT;
      return t[RND_W-1:0];
   endfunction

   // Saturate to the signed 16-bit sample range.
   function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [SMP_W-1:0] s;
      if (v > SMP_MAX) begin
         s = 16'sh7fff;
      end else if (v < SMP_MIN) begin
         s = -16'sh8000;
      end else begin
         s = v[SMP_W-1:0];
      end
      return s;
   endfunction

endpackage

// File: rtl/fractional_feedback_delay_line.sv
// Top level of the fractional feedback delay line: configuration registers, sample store,
// shared multiplier datapath and output register. Depends on ffdl_pkg and ffdl_seq.
//
// Interleaved 16-bit samples enter on the req_ channel and one mixed sample leaves on the
// rsp_ channel per transaction. After acceptance the microprogram reads the two neighbouring
// store entries through the single read port and then runs the interpolation, feedback and
// mix products one after another through one shared multiplier before the result is loaded
// into the output register. A new item is accepted only after the previous result is loaded;
// a result waiting in the output register does not block acceptance. After reset the store
// is cleared one entry a cycle, and no item is accepted until that pass ends; configuration
// writes are taken at any time but are meant to be made only while the block is idle.
module fractional_feedback_delay_line
   import ffdl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Input sample channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SMP_W-1:0]     req_in_sample,
   input  logic                        req_block_end,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SMP_W-1:0]     rsp_out_sample,
   output logic                        rsp_block_end_out,
   // Configuration write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [DELAY_W-1:0] delay_ff;
   logic [CHREG_W-1:0] channels_ff;
   logic [FB_W-1:0]    feedback_ff;
   logic [GAIN_W-1:0]  dry_ff;
   logic [GAIN_W-1:0]  wet_gain_ff;

   // Sequencer interface.
   seq_ctrl_type   ctrl;
   seq_status_type status;
   ctrl_word_type  cw;

   // Item state.
   logic signed [SMP_W-1:0] x_ff;
   logic                    be_ff;
   logic [ADDR_W-1:0]       wp_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [ADDR_W-1:0]       nidx_ff;
   logic [ADDR_W-1:0]       clr_cnt_ff;

   // Datapath registers.
   logic signed [SMP_W-1:0] rdata_ff;
   logic signed [MUL_W-1:0] prod_ff;
   logic signed [MUL_W-1:0] acc_ff;
   logic signed [WET_W-1:0] wet_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic signed [SMP_W-1:0] rsp_sample_ff;
   logic                    rsp_be_ff;

   // Sample store.
   logic [SMP_W-1:0] mem [STORE_DEPTH];

   // Derived geometry.
   logic [CH_W-1:0]   ch_eff;
   logic [LEN_W-1:0]  len;
   logic [SPAN_W-1:0] span;
   logic [DLY_W-1:0]  delay_eff;
   logic [DLY_W-1:0]  delay_cap;
   logic [SPAN_W-1:0] offset;
   logic [SPAN_W:0]   pos_raw;
   logic [POS_W-1:0]  pos_new;
   logic [ADDR_W-1:0] wp_eff;
   logic [LEN_W-1:0]  wp_inc;
   logic [ADDR_W-1:0] wp_next;
   logic [ADDR_W-1:0] idx;
   logic [LEN_W-1:0]  idx_inc;
   logic [ADDR_W-1:0] nidx_new;
   logic [FRAC_BITS-1:0] frac;
   logic [FRAC_BITS:0]   frac_inv;

   // Multiplier and result logic.
   logic signed [WET_W-1:0]  mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [WET_W-1:0]  x_ext;
   logic signed [MUL_W-1:0]  wet_sum;
   logic signed [SUM_W-1:0]  out_sum;
   logic signed [SMP_W-1:0]  st_val;
   logic signed [SMP_W-1:0]  out_val;

   // Store write and read ports.
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [SMP_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic req_fire;
   logic out_go;

   // Sequencer.
   ffdl_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign cw = ctrl.word;

   assign status.req_valid = req_valid;
   assign status.clr_done  = (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = !cw.req_rdy;
   assign req_fire  = req_valid && !req_stall;
   assign out_go    = cw.out_ld && ctrl.go;
   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_W'(256);
         channels_ff <= CHREG_W'(1);
         feedback_ff <= FB_W'(16384);
         dry_ff      <= GAIN_W'(16384);
         wet_gain_ff <= GAIN_W'(16384);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DELAY:    delay_ff    <= csr_wdata[DELAY_W-1:0];
            CSR_CHANNELS: channels_ff <= csr_wdata[CHREG_W-1:0];
            CSR_FEEDBACK: feedback_ff <= csr_wdata[FB_W-1:0];
            CSR_DRY:      dry_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_WET:      wet_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective channel count, store length and delay.
   always_comb begin
      if (channels_ff == '0) begin
         ch_eff = CH_W'(1);
      end else if (CH_W'(channels_ff) > CH_W'(MAX_CHANNELS)) begin
         ch_eff = CH_W'(MAX_CHANNELS);
      end else begin
         ch_eff = CH_W'(channels_ff);
      end
      len       = LEN_W'(MAX_FRAMES) * LEN_W'(ch_eff);
      span      = {len, {FRAC_BITS{1'b0}}};
      delay_cap = DLY_W'(MAX_FRAMES) << FRAC_BITS;
      delay_eff = (DLY_W'(delay_ff) > delay_cap) ? delay_cap : DLY_W'(delay_ff);
   end

   // Write position, normalised against the current length, and its successor.
   always_comb begin
      wp_eff  = (LEN_W'(wp_ff) >= len) ? '0 : wp_ff;
      wp_inc  = LEN_W'(wp_eff) + LEN_W'(1);
      wp_next = (wp_inc >= len) ? '0 : wp_inc[ADDR_W-1:0];
   end

   // Read point behind the write position, wrapped into one store length.
   always_comb begin
      offset  = SPAN_W'(delay_eff) * SPAN_W'(ch_eff);
      pos_raw = (SPAN_W + 1)'({wp_eff, {FRAC_BITS{1'b0}}}) + (SPAN_W + 1)'(span)
                - (SPAN_W + 1)'(offset);
      if (pos_raw >= (SPAN_W + 1)'(span)) begin
         pos_new = POS_W'(pos_raw - (SPAN_W + 1)'(span));
      end else begin
         pos_new = POS_W'(pos_raw);
      end
   end

   // Neighbouring entry index and interpolation weights.
   always_comb begin
      idx      = pos_ff[POS_W-1 -: ADDR_W];
      frac     = pos_ff[FRAC_BITS-1:0];
      frac_inv = (FRAC_BITS + 1)'(SCALE) - (FRAC_BITS + 1)'(frac);
      idx_inc  = LEN_W'(idx) + LEN_W'(1);
      nidx_new = (idx_inc >= len) ? '0 : idx_inc[ADDR_W-1:0];
   end

   // Clearing counter, item capture, read pointers and write position.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cw.clr_wr && !status.clr_done) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (out_go) begin
            wp_ff <= wp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= req_in_sample;
         be_ff  <= req_block_end;
         pos_ff <= pos_new;
      end
      if (cw.nidx_ld) begin
         nidx_ff <= nidx_new;
      end
   end

   // Store access: clearing pass or feedback write, and one registered read.
   always_comb begin
      x_ext   = WET_W'(x_ff);
      st_val  = sat16(SAT_W'(x_ff) + SAT_W'(round_shift(SUM_W'(prod_ff))));
      mem_we    = cw.clr_wr || cw.st_wr;
      mem_waddr = cw.clr_wr ? clr_cnt_ff : wp_eff;
      mem_wdata = cw.clr_wr ? '0 : st_val;
      mem_re    = (cw.rd_sel != RD_NONE);
      mem_raddr = (cw.rd_sel == RD_NEXT) ? nidx_ff : idx;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cw.mul_sel)
         MUL_PREV: begin
            mul_a = WET_W'(rdata_ff);
            mul_b = MULB_W'(frac_inv);
         end
         MUL_NEXT: begin
            mul_a = WET_W'(rdata_ff);
            mul_b = MULB_W'(frac);
         end
         MUL_DRY: begin
            mul_a = x_ext <<< FRAC_BITS;
            mul_b = MULB_W'(dry_ff);
         end
         MUL_FB: begin
            mul_a = wet_ff;
            mul_b = MULB_W'(feedback_ff);
         end
         MUL_WG: begin
            mul_a = wet_ff;
            mul_b = MULB_W'(wet_gain_ff);
         end
         default: begin
            mul_a = wet_ff;
            mul_b = '0;
         end
      endcase
   end

   // Product, accumulator and interpolated wet value.
   assign wet_sum = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (cw.mul_sel != MUL_HOLD) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cw.acc_ld) begin
         acc_ff <= prod_ff;
      end
      if (cw.wet_ld) begin
         wet_ff <= wet_sum[WET_W-1:0];
      end
   end

   // Dry plus wet mix, rounded and saturated.
   always_comb begin
      out_sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);
      out_val = sat16(SAT_W'(round_shift(out_sum)));
   end

   // Output register: holds a result until the downstream side takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         rsp_sample_ff <= out_val;
         rsp_be_ff     <= be_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_sample    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_be_ff;

endmodule

// File: rtl/ffdl_seq.sv
// Microcode sequencer of the delay line: step counter, control store lookup and
// conditional jumps. Depends on ffdl_pkg for the control word and the microprogram.
module ffdl_seq
   import ffdl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output seq_ctrl_type   ctrl
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   ctrl_word_type     word;
   logic              go;

   // Fetch the control word and evaluate its jump condition.
   always_comb begin
      word = ucode(pc_ff);
      unique case (word.cond)
         C_ALWAYS:   go = 1'b1;
         C_CLR_DONE: go = status.clr_done;
         C_REQ:      go = status.req_valid;
         C_OUT_FREE: go = status.out_free;
         default:    go = 1'b1;
      endcase
      pc_in = go ? word.target : pc_ff;
   end

   assign ctrl.word = word;
   assign ctrl.go   = go;

   // Step counter; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
